@@ rtl/scm_pkg.sv @@
// ----------------------------------------------------------------------------
// scm_pkg
// shared types and constants of the stereo correlation meter
// ----------------------------------------------------------------------------
package scm_pkg;

    // fixed widths of the window sums and the energy product
    localparam int unsigned CROSS_W = 44;
    localparam int unsigned ENERGY_W = 43;
    localparam int unsigned PROD_W = 2 * ENERGY_W;
    localparam int unsigned ROOT_W = ENERGY_W;
    localparam int unsigned FRAC_BITS = 15;
    localparam int unsigned RESULT_W = 16;
    localparam int unsigned CFG_W = 13;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 13'd1024;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_start;   // start a clearing pass
        logic clear_step;    // write zeros at the clear address
        logic load;          // capture input word, issue history read
        logic update;        // update sums, write history, advance position
        logic mul_start;     // start energy product
        logic mul_step;      // one partial product step
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic finish;        // form the result word
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_done;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic zero_energy;
        logic skip_div;
    } t_status;

endpackage

@@ rtl/scm_ram.sv @@
// ----------------------------------------------------------------------------
// scm_ram
// generic single-port-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module scm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/scm_datapath.sv @@
// ----------------------------------------------------------------------------
// scm_datapath
// history memories, window sums, product, square root and divider
// ----------------------------------------------------------------------------
module scm_datapath #(
    parameter int unsigned MAX_WINDOW = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scm_pkg::t_cmd                i_cmd,
    output scm_pkg::t_status             o_status,
    input  logic [scm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_cfg_we,
    input  logic signed [15:0]           i_left_sample,
    input  logic signed [15:0]           i_right_sample,
    output logic signed [15:0]           o_result
);

    localparam int unsigned AW = $clog2(MAX_WINDOW);
    localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CW = scm_pkg::CROSS_W;
    localparam int unsigned EW = scm_pkg::ENERGY_W;
    localparam int unsigned PW = scm_pkg::PROD_W;
    localparam int unsigned RW = scm_pkg::ROOT_W;
    localparam int unsigned SB = SAMPLE_BITS;
    localparam int unsigned HALF = (EW + 1) / 2;
    localparam logic [LEN_W-1:0] MAXW = LEN_W'(MAX_WINDOW);

    // window length register, saturated on write
    logic [LEN_W-1:0] r_len;
    logic [scm_pkg::CFG_W-1:0] cfg_v;
    logic [LEN_W-1:0] n_len;
    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) begin
            n_len = LEN_W'(1);
        end else if ({{(32-scm_pkg::CFG_W){1'b0}}, cfg_v} > MAX_WINDOW) begin
            n_len = MAXW;
        end else begin
            n_len = LEN_W'(cfg_v);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(scm_pkg::WINDOW_RESET > MAX_WINDOW ? MAX_WINDOW
                             : scm_pkg::WINDOW_RESET);
        end else if (i_cfg_we) begin
            r_len <= n_len;
        end
    end

    // clearing pass address
    logic [AW:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_start) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_status.clear_done = r_clr[AW] ||
        ({{(31-AW){1'b0}}, r_clr} >= MAX_WINDOW - 1 && i_cmd.clear_step);

    // input words and position
    logic signed [SB-1:0] r_l, r_r;
    logic [AW-1:0] r_pos;
    logic signed [SB-1:0] ol, orr;
    logic [AW-1:0] pos_eff;
    assign pos_eff = (LEN_W'(r_pos) >= r_len) ? '0 : r_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_l <= SB'(i_left_sample);
            r_r <= SB'(i_right_sample);
        end
    end

    logic [AW-1:0] pos_next;
    assign pos_next = (LEN_W'(pos_eff) + 1'b1 >= r_len) ? '0 : AW'(pos_eff + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.clear_start) begin
            r_pos <= '0;
        end else if (i_cmd.update) begin
            r_pos <= pos_next;
        end
    end

    // history memories
    logic ram_we;
    logic [AW-1:0] ram_wa;
    logic [SB-1:0] wl, wr;
    assign ram_we = i_cmd.clear_step || i_cmd.update;
    assign ram_wa = i_cmd.clear_step ? r_clr[AW-1:0] : pos_eff;
    assign wl = i_cmd.clear_step ? '0 : r_l;
    assign wr = i_cmd.clear_step ? '0 : r_r;

    scm_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_left_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(wl),
        .i_raddr(pos_eff), .o_rdata(ol)
    );
    scm_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_right_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(wr),
        .i_raddr(pos_eff), .o_rdata(orr)
    );

    // window sums: add newest products, subtract oldest
    logic [CW-1:0] r_sx;
    logic [EW-1:0] r_sl, r_sr;
    logic signed [2*SB-1:0] p_lr, p_ll, p_rr, o_lr, o_ll, o_rr;
    assign p_lr = r_l * r_r;
    assign p_ll = r_l * r_l;
    assign p_rr = r_r * r_r;
    assign o_lr = ol * orr;
    assign o_ll = ol * ol;
    assign o_rr = orr * orr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_start) begin
            r_sx <= '0;
            r_sl <= '0;
            r_sr <= '0;
        end else if (i_cmd.update) begin
            r_sx <= r_sx + CW'(p_lr) - CW'(o_lr);
            r_sl <= r_sl + EW'(p_ll) - EW'(o_ll);
            r_sr <= r_sr + EW'(p_rr) - EW'(o_rr);
        end
    end

    // energy product, four partial products of half width
    logic [PW-1:0] r_prod;
    logic [1:0] r_mcnt;
    logic [HALF-1:0] ma, mb;
    logic [EW:0] sl_x, sr_x;
    logic [2*HALF-1:0] pp;
    assign sl_x = {1'b0, r_sl};
    assign sr_x = {1'b0, r_sr};
    assign ma = r_mcnt[1] ? HALF'(sl_x >> HALF) : HALF'(sl_x);
    assign mb = r_mcnt[0] ? HALF'(sr_x >> HALF) : HALF'(sr_x);
    assign pp = ma * mb;
    logic [7:0] sh;
    assign sh = 8'(HALF) * (8'(r_mcnt[1]) + 8'(r_mcnt[0]));
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_prod <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= r_prod + (PW'(pp) << sh);
            r_mcnt <= r_mcnt + 1'b1;
        end
    end
    logic r_mdone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.mul_start) begin
            r_mdone <= 1'b0;
        end else if (i_cmd.mul_step && r_mcnt == 2'd3) begin
            r_mdone <= 1'b1;
        end
    end
    assign o_status.mul_done = r_mdone;
    assign o_status.zero_energy = (r_prod == '0);

    // restoring square root, one result bit per step
    localparam int unsigned SQW = PW + 2;
    logic [PW-1:0] r_rad;
    logic [SQW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [$clog2(RW+1)-1:0] r_scnt;
    logic [SQW-1:0] s_rem, s_trial;
    assign s_rem = {r_rem[SQW-3:0], r_rad[PW-1:PW-2]};
    assign s_trial = {{(SQW-RW-2){1'b0}}, r_root, 2'b01};
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad <= r_prod;
            r_rem <= '0;
            r_root <= '0;
            r_scnt <= '0;
        end else if (i_cmd.sqrt_step && !o_status.sqrt_done) begin
            r_rad <= r_rad << 2;
            r_scnt <= r_scnt + 1'b1;
            if (s_rem >= s_trial) begin
                r_rem <= s_rem - s_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem <= s_rem;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end
    assign o_status.sqrt_done = (r_scnt == ($clog2(RW+1))'(RW));

    // sign and magnitude of the cross sum
    logic neg;
    logic [CW-1:0] mag;
    assign neg = r_sx[CW-1];
    assign mag = neg ? (~r_sx + 1'b1) : r_sx;
    logic [CW:0] root_x, mag_x;
    assign root_x = (CW+1)'(r_root);
    assign mag_x = {1'b0, mag};
    assign o_status.skip_div = (mag_x >= root_x);

    // restoring division, fifteen quotient bits
    logic [CW+1:0] r_drem;
    logic [16:0] r_q;
    logic [3:0] r_dcnt;
    logic [CW+1:0] d_sh;
    assign d_sh = {r_drem[CW:0], 1'b0};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_drem <= {1'b0, mag_x};
            r_dcnt <= '0;
            if (mag_x > root_x && neg) begin
                r_q <= 17'd32769;
            end else if (mag_x >= root_x) begin
                r_q <= 17'd32768;
            end else begin
                r_q <= '0;
            end
        end else if (i_cmd.div_step && r_dcnt != 4'(scm_pkg::FRAC_BITS)) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (d_sh >= (CW+2)'(r_root)) begin
                r_drem <= d_sh - (CW+2)'(r_root);
                r_q <= {r_q[15:0], 1'b1};
            end else begin
                r_drem <= d_sh;
                r_q <= {r_q[15:0], 1'b0};
            end
        end
    end
    assign o_status.div_done = (r_dcnt == 4'(scm_pkg::FRAC_BITS));

    // saturation and result word
    logic [15:0] r_res;
    logic [16:0] qs;
    always_comb begin
        if (o_status.zero_energy) begin
            qs = '0;
        end else if (neg) begin
            qs = (r_q > 17'd32768) ? 17'd32768 : r_q;
            qs = 17'h10000 - qs;
        end else begin
            qs = (r_q > 17'd32767) ? 17'd32767 : r_q;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= qs[15:0];
        end
    end
    assign o_result = r_res;

`ifndef SYNTHESIS
    // history position stays inside the memory
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {{(31-AW){1'b0}}, 1'b0, r_pos} < MAX_WINDOW)
        else $error("position out of range");
    // window length stays within limits
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 && r_len <= MAXW)
        else $error("window length out of range");
    // a clearing pass leaves all sums at zero
    a_clear_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_start |=> (r_sx == '0 && r_sl == '0 && r_sr == '0))
        else $error("sums not cleared");
`endif

endmodule

@@ rtl/scm_ctrl.sv @@
// ----------------------------------------------------------------------------
// scm_ctrl
// sequencer for clearing, sum update, product, root, divide and output word
// ----------------------------------------------------------------------------
module scm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scm_pkg::t_status i_status,
    input  logic             i_cfg_we,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_cfg_ready,
    output scm_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_UPD   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_SQRT  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid;

    // output word holding register flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.clear_start = i_cfg_we;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done && !i_cfg_we) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_CLEAR;
                end else if (i_in_valid && !r_out_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_UPD;
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!i_status.mul_done) begin
                    o_cmd.mul_step = 1'b1;
                end
                if (i_status.mul_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_status.sqrt_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.zero_energy || i_status.skip_div || i_status.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
        if (r_state == S_UPD) begin
            o_cmd.mul_start = 1'b1;
        end
    end

    assign o_in_stall = !(r_state == S_IDLE && !r_out_valid && !i_cfg_we);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);

`ifndef SYNTHESIS
    // no word taken while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    // an accepted word leads through the read state to the sum update
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 (r_state == S_UPD))
        else $error("update not issued");
    // result flag rises only after the finish step
    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without finish");
`endif

endmodule

@@ rtl/stereo_correlation_meter.sv @@
// an accepted word passes through the read, update, product, square root, divide
// and finish states to the result word; the divide is skipped when the quotient
// saturates or the energy is zero. No new word is taken before the result word of
// the last one has been taken; the time per word is set by the 43-step square root
// of the 86-bit energy product and the 15-step divider. Reset and each window
// length write run a clearing pass over the history memories, during which no input word is taken
// ----------------------------------------------------------------------------
// stereo_correlation_meter
// sliding window stereo phase correlation, signed q1.15 result
// ----------------------------------------------------------------------------
module stereo_correlation_meter #(
    parameter int unsigned MAX_WINDOW = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [15:0]        i_left_sample,
    input  logic signed [15:0]        i_right_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [15:0]        o_correlation,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [scm_pkg::CFG_W-1:0] i_cfg_window_len
);

    scm_pkg::t_cmd cmd;
    scm_pkg::t_status status;
    logic cfg_we;
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // sequencer
    scm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_status(status), .i_cfg_we(cfg_we),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cfg_ready(o_cfg_ready), .o_cmd(cmd)
    );

    // arithmetic and storage
    scm_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_data(i_cfg_window_len), .i_cfg_we(cfg_we),
        .i_left_sample(i_left_sample), .i_right_sample(i_right_sample),
        .o_result(o_correlation)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo correlation meter: random audio, two directed
// tables of sample pairs, then random correlated and uncorrelated audio over several
// window lengths, each result compared with a typed value or a bit-exact correlation predictor
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned HIST_DEPTH = 4096;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned EXP_DEPTH = 16;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [15:0]          i_left_sample = '0;
    logic signed [15:0]          i_right_sample = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [15:0]          o_correlation;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [scm_pkg::CFG_W-1:0]   i_cfg_window_len = '0;

    stereo_correlation_meter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_correlation    (o_correlation),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_window_len (i_cfg_window_len)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0]   left_hist [HIST_DEPTH];
    logic signed [15:0]   right_hist [HIST_DEPTH];
    int unsigned          oldest_pos;
    int unsigned          win_len;
    logic signed [63:0]   cross_sum;
    logic signed [63:0]   left_energy;
    logic signed [63:0]   right_energy;

    // expected result words, written at exp_wr and read at exp_rd
    logic signed [15:0]   exp_words [EXP_DEPTH];
    int unsigned          exp_wr = 0;
    int unsigned          exp_rd = 0;
    int                   error_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void set_window_len(input logic [scm_pkg::CFG_W-1:0] v);
        win_len = (v == 0) ? 1 : (v > HIST_DEPTH ? HIST_DEPTH : v);
        for (int i = 0; i < HIST_DEPTH; i++) begin
            left_hist[i] = '0;
            right_hist[i] = '0;
        end
        oldest_pos = 0;
        cross_sum = '0;
        left_energy = '0;
        right_energy = '0;
    endfunction

    // slide the window by one pair and work out the q1.15 correlation
    function automatic logic signed [15:0] slide_correlation(
        input logic signed [15:0] l, input logic signed [15:0] r);
        logic signed [63:0] ol, orr, ll, rr;
        logic [127:0] energy_prod, sq;
        logic [63:0] root, cand, mag, rem;
        logic [16:0] q;
        logic neg;
        int unsigned pos;
        pos = (oldest_pos >= win_len) ? 0 : oldest_pos;
        ol = left_hist[pos];
        orr = right_hist[pos];
        ll = l;
        rr = r;
        cross_sum = cross_sum + ll * rr - ol * orr;
        left_energy = left_energy + ll * ll - ol * ol;
        right_energy = right_energy + rr * rr - orr * orr;
        left_hist[pos] = l;
        right_hist[pos] = r;
        pos++;
        oldest_pos = (pos >= win_len) ? 0 : pos;

        energy_prod = {64'd0, left_energy} * {64'd0, right_energy};
        if (energy_prod == 0) return 16'sd0;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= energy_prod) root = cand;
        end
        neg = cross_sum[63];
        mag = neg ? -cross_sum : cross_sum;
        if (mag >= root) begin
            q = (mag > root && neg) ? 17'd32769 : 17'd32768;
        end else begin
            rem = mag;
            q = '0;
            for (int i = 0; i < 15; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= root) begin
                    rem = rem - root;
                    q[0] = 1'b1;
                end
            end
        end
        if (neg) begin
            if (q > 32768) q = 32768;
            return 16'(17'h10000 - q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                report_mismatch($sformatf("unexpected word %0d", o_correlation));
            end else begin
                if (o_correlation !== exp_words[exp_rd % EXP_DEPTH])
                    report_mismatch($sformatf("correlation %0d, expected %0d",
                                              o_correlation,
                                              exp_words[exp_rd % EXP_DEPTH]));
                exp_rd++;
            end
        end
    end

    // push one sample pair; a typed expectation overrides the predicted one
    task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                             input bit typed, input logic signed [15:0] typed_corr);
        logic signed [15:0] pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        do @(posedge i_clk); while (o_in_stall);
        pred = slide_correlation(l, r);
        exp_words[exp_wr % EXP_DEPTH] = typed ? typed_corr : pred;
        exp_wr++;
        @(negedge i_clk);
    endtask

    task automatic write_window(input logic [scm_pkg::CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        wait (exp_wr == exp_rd);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_window_len <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_window_len(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random audio: correlated pairs in half the cases, the rest noise and extremes
    task automatic send_random(input int count);
        logic signed [15:0] l, r;
        for (int n = 0; n < count; n++) begin
            l = 16'($urandom);
            case ($urandom_range(5))
                0: r = l;
                1: r = -l;
                2: r = 16'(l >>> $urandom_range(4)) + 16'($urandom_range(63)) - 16'sd32;
                3: r = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
                default: r = 16'($urandom);
            endcase
            if ($urandom_range(15) == 0) l = 16'($urandom_range(3)) - 16'sd1;
            send_pair(l, r, 1'b0, '0);
        end
    endtask

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
        bit                 typed;
        logic signed [15:0] corr;
    } t_pair_row;

    // window of one pair: sign of the product at full scale, zero on no energy
    t_pair_row pair_table [11] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd32767,  16'sd32767,  1'b1, 16'sd32767},
        '{16'sh8000,   16'sh8000,   1'b1, 16'sd32767},
        '{16'sh8000,   16'sd32767,  1'b1, 16'sh8000},
        '{16'sd32767,  16'sh8000,   1'b1, 16'sh8000},
        '{16'sd1,      16'sd1,      1'b1, 16'sd32767},
        '{-16'sd1,     16'sd1,      1'b1, 16'sh8000},
        '{16'sd0,      16'sh8000,   1'b1, 16'sd0},
        '{16'sd12345,  16'sd0,      1'b1, 16'sd0},
        '{-16'sd1,     -16'sd1,     1'b1, 16'sd32767},
        '{16'sh5555,   16'shaaaa,   1'b1, 16'sh8000}
    };

    // window of two pairs: partial correlation and negative overshoot
    t_pair_row mix_table [8] = '{
        '{16'sd100,    -16'sd50,    1'b0, 16'sd0},
        '{16'sd3,      16'sd7,      1'b0, 16'sd0},
        '{16'sd32767,  16'sd1,      1'b0, 16'sd0},
        '{16'sh8000,   16'sd32767,  1'b0, 16'sd0},
        '{16'sd2,      -16'sd3,     1'b0, 16'sd0},
        '{-16'sd3,     16'sd2,      1'b0, 16'sd0},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0}
    };

    initial begin
        set_window_len(scm_pkg::WINDOW_RESET);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset window length, light noise
        send_random(40);

        write_window('0);
        foreach (pair_table[i])
            send_pair(pair_table[i].l, pair_table[i].r, pair_table[i].typed,
                      pair_table[i].corr);
        write_window(13'd2);
        foreach (mix_table[i])
            send_pair(mix_table[i].l, mix_table[i].r, 1'b0, '0);

        // three idling regimes over several window lengths
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1 ? 73 : 0);
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1 ? 6 : 0);
            write_window(13'd1);
            send_random(60);
            write_window(13'd7);
            send_random(120);
            write_window(13'($urandom_range(300, 3)));
            send_random(120);
            write_window(ph == 2 ? 13'd8191 : 13'd4096);
            send_random(220);
        end
        write_window(13'd100);
        send_random(40);

        i_in_valid <= 1'b0;
        wait (exp_wr == exp_rd);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/scm_pkg.sv
rtl/scm_ram.sv
rtl/scm_datapath.sv
rtl/scm_ctrl.sv
rtl/stereo_correlation_meter.sv
bench/tb_top.sv
